FILE: rtl/tgr_pkg.sv
// Shared types and constants for the transition graph reachability block.
`timescale 1ns / 1ps
`default_nettype none
package tgr_pkg;

   localparam int TGR_MAX_VARIABLES = 16;
   localparam int TGR_MAX_DOMAIN    = 64;

   // Request beat layout
   localparam int REQ_TDATA_W = 88;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [1:0] {
      MODE_ADD_EDGE = 2'd0,
      MODE_ADD_ALL  = 2'd1,
      MODE_QUERY    = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [3:0]  variable;
      logic [5:0]  from_value;
      logic [5:0]  to_value;
      logic [6:0]  dom_size;
      logic [63:0] exclude_mask;
   } item_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic connected;
   } eng_status_type;

endpackage
`default_nettype wire

FILE: rtl/tgr_engine.sv
// Sequencer, successor row memory and shared row merge unit.
`timescale 1ns / 1ps
`default_nettype none
module tgr_engine
   import tgr_pkg::*;
#(
   parameter int MAX_VARIABLES = TGR_MAX_VARIABLES,
   parameter int MAX_DOMAIN    = TGR_MAX_DOMAIN
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire item_type       item,
   input  wire logic           out_free,
   output eng_status_type      status
);

   localparam int ROWS = MAX_VARIABLES * MAX_DOMAIN;
   localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int VW   = $clog2(MAX_DOMAIN);
   localparam logic [MAX_DOMAIN-1:0] BIT0 = {{(MAX_DOMAIN-1){1'b0}}, 1'b1};

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_ADD    = 7'b0000100,
      ST_PICK   = 7'b0001000,
      ST_MERGE  = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_SPARE  = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [AW-1:0]         end_ff, end_in;
   logic [AW-1:0]         base_ff, base_in;
   logic [VW-1:0]         val_ff, val_in;
   logic [VW-1:0]         dst_ff, dst_in;
   logic [MAX_DOMAIN-1:0] visited_ff, visited_in;
   logic [MAX_DOMAIN-1:0] frontier_ff, frontier_in;
   logic                  conn_ff, conn_in;
   logic                  done;

   logic [MAX_DOMAIN-1:0] row_mem [ROWS];
   logic [MAX_DOMAIN-1:0] rd_data_ff;
   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [MAX_DOMAIN-1:0] wr_data;

   // Item decode
   logic                  var_ok, src_ok, dst_ok;
   logic [VW-1:0]         src_i, dst_i, pick;
   logic [AW-1:0]         item_base;
   logic [6:0]            dom_lim;
   logic [MAX_DOMAIN-1:0] excl_m, start_bit, fresh;

   assign var_ok    = 32'(item.variable) < MAX_VARIABLES;
   assign src_ok    = 32'(item.from_value) < MAX_DOMAIN;
   assign dst_ok    = 32'(item.to_value) < MAX_DOMAIN;
   assign src_i     = item.from_value[VW-1:0];
   assign dst_i     = item.to_value[VW-1:0];
   assign item_base = AW'(32'(item.variable) * MAX_DOMAIN);
   assign dom_lim   = (item.dom_size > 7'(MAX_DOMAIN)) ? 7'(MAX_DOMAIN)
                                                       : item.dom_size;
   assign excl_m    = item.exclude_mask[MAX_DOMAIN-1:0];
   assign start_bit = BIT0 << src_i;

   // Lowest pending value in the frontier
   always_comb begin
      pick = '0;
      for (int i = MAX_DOMAIN - 1; i >= 0; i--) begin
         if (frontier_ff[i]) pick = VW'(i);
      end
   end

   assign fresh = rd_data_ff & ~visited_ff;

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      end_in      = end_ff;
      base_in     = base_ff;
      val_in      = val_ff;
      dst_in      = dst_ff;
      visited_in  = visited_ff;
      frontier_in = frontier_ff;
      conn_in     = conn_ff;
      wr_en       = 1'b0;
      wr_addr     = addr_ff;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = addr_ff;
      done        = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (addr_ff == AW'(ROWS - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               unique case (item.mode)
                  MODE_ADD_EDGE: begin
                     if (var_ok && src_ok && dst_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = item_base + AW'(src_i);
                        addr_in  = item_base + AW'(src_i);
                        end_in   = item_base + AW'(src_i);
                        val_in   = src_i;
                        dst_in   = dst_i;
                        state_in = ST_ADD;
                     end
                  end
                  MODE_ADD_ALL: begin
                     if (var_ok && dst_ok && (item.dom_size != 7'd0)) begin
                        rd_en    = 1'b1;
                        rd_addr  = item_base;
                        addr_in  = item_base;
                        end_in   = item_base + AW'(dom_lim) - AW'(1);
                        val_in   = '0;
                        dst_in   = dst_i;
                        state_in = ST_ADD;
                     end
                  end
                  MODE_QUERY: begin
                     conn_in  = 1'b0;
                     base_in  = item_base;
                     dst_in   = dst_i;
                     state_in = ST_FINISH;
                     if (var_ok && src_ok && dst_ok && !excl_m[src_i]) begin
                        if (src_i == dst_i) begin
                           conn_in = 1'b1;
                        end else if (!excl_m[dst_i]) begin
                           visited_in  = excl_m | start_bit;
                           frontier_in = start_bit;
                           state_in    = ST_PICK;
                        end
                     end
                  end
                  MODE_NONE: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            // read-modify-write; next row is read while this one is written
            wr_en   = 1'b1;
            wr_data = rd_data_ff | ((val_ff != dst_ff) ? (BIT0 << dst_ff) : '0);
            if (addr_ff == end_ff) begin
               state_in = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = addr_ff + AW'(1);
               addr_in = addr_ff + AW'(1);
               val_in  = val_ff + VW'(1);
            end
         end
         ST_PICK: begin
            if (visited_ff[dst_ff]) begin
               conn_in  = 1'b1;
               state_in = ST_FINISH;
            end else if (frontier_ff == '0) begin
               conn_in  = 1'b0;
               state_in = ST_FINISH;
            end else begin
               frontier_in = frontier_ff & ~(BIT0 << pick);
               rd_en       = 1'b1;
               rd_addr     = base_ff + AW'(pick);
               state_in    = ST_MERGE;
            end
         end
         ST_MERGE: begin
            visited_in  = visited_ff | fresh;
            frontier_in = frontier_ff | fresh;
            state_in    = ST_PICK;
         end
         ST_FINISH: begin
            done = out_free;
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign status.idle      = (state_ff == ST_IDLE);
   assign status.done      = done;
   assign status.connected = conn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff      <= end_in;
      base_ff     <= base_in;
      val_ff      <= val_in;
      dst_ff      <= dst_in;
      visited_ff  <= visited_in;
      frontier_ff <= frontier_in;
      conn_ff     <= conn_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) row_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= row_mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: rtl/transition_graph_reachability.sv
// Top level: stream ports, result register and the graph engine.
`timescale 1ns / 1ps
`default_nettype none
// Per-variable value transition graphs held as one successor row per value in a
// single-port-read row memory, with a reachability query, expanding the lowest
// pending value first, that avoids a mask of excluded values. After reset the
// memory is swept clear, one row a cycle, over all MAX_VARIABLES*MAX_DOMAIN
// rows (1024 at the defaults); req_tready stays low meanwhile. Items are handled
// one at a time: an add edge reads its row and writes it back, an add from every
// value does the same for each row of the domain in turn, and a searched query
// expands one value at a time, each expansion being one row read followed by
// one merge. A finished result waits in an output register, and the next item
// is taken while it waits; a query that finishes while that register is still
// full holds the engine, and req_tready low, until the waiting beat is taken.
module transition_graph_reachability
   import tgr_pkg::*;
#(
   parameter int MAX_VARIABLES = TGR_MAX_VARIABLES,
   parameter int MAX_DOMAIN    = TGR_MAX_DOMAIN
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // variable[3:0], from_value[9:4], to_value[15:10], dom_size[22:16],
   // exclude_mask[86:23], zero pad[87]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // mode[1:0]
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // connected[0], zero pad[7:1]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   item_type       item;
   eng_status_type status;
   logic           start, out_free;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_conn_ff, rsp_conn_in;

   assign item.mode         = mode_type'(req_tuser);
   assign item.variable     = req_tdata[3:0];
   assign item.from_value   = req_tdata[9:4];
   assign item.to_value     = req_tdata[15:10];
   assign item.dom_size     = req_tdata[22:16];
   assign item.exclude_mask = req_tdata[86:23];

   assign req_tready = status.idle;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   tgr_engine #(
      .MAX_VARIABLES (MAX_VARIABLES),
      .MAX_DOMAIN    (MAX_DOMAIN)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .item     (item),
      .out_free (out_free),
      .status   (status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_conn_in  = rsp_conn_ff;
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_conn_in  = status.connected;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_conn_ff <= rsp_conn_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-1){1'b0}}, rsp_conn_ff};

`ifndef NO_ASSERTIONS
   // a query always occupies the engine past its accept beat
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == MODE_QUERY)) |=> !req_tready)
      else $error("engine ready right after query beat");

   // a finished result never lands on a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");
`endif

endmodule
`default_nettype wire
